[src/oaht_pkg.sv]
package oaht_pkg;

	localparam int MaxSlots    = 2048;
	localparam int InitialSize = 11;
	localparam int StepPrime   = 7;
	localparam int IdxW        = 11;
	localparam int AddrW       = 12;
	localparam int CntW        = 12;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FOUND     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [1:0] PM_LINEAR    = 2'd0;
	localparam logic [1:0] PM_QUADRATIC = 2'd1;

	localparam logic OP_INSERT = 1'b0;

	typedef struct packed {
		logic [63:0] tag;
		logic [7:0]  key;
		logic [31:0] txns;
		logic [31:0] items;
		logic [31:0] cents;
	} slot_rec_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_GROW_START,
		S_PRIME_TRY,
		S_PRIME_DIV,
		S_PRIME_NEXT,
		S_PROBE_START,
		S_HOME_DIV,
		S_PROBE_RD,
		S_PROBE_WAIT,
		S_PROBE_CHK,
		S_PROBE_ADV,
		S_PROBE_MOD,
		S_INS_WRITE,
		S_CLR,
		S_RH_RD,
		S_RH_WAIT,
		S_RH_CHK,
		S_RH_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        start;
		logic [23:0] dividend;
		logic [11:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [11:0] rem;
	} div_rsp_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		to_lower = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
	endfunction

endpackage

[src/oaht_if.sv]
interface oaht_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [63:0] name_tag;
	logic [7:0]  first_letter;
	logic [7:0]  last_letter;
	logic [31:0] txn_count;
	logic [31:0] item_count;
	logic [31:0] paid_cents;
	modport source(output valid, opcode, name_tag, first_letter, last_letter,
		txn_count, item_count, paid_cents, input ready);
	modport sink(input valid, opcode, name_tag, first_letter, last_letter,
		txn_count, item_count, paid_cents, output ready);
endinterface

interface oaht_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] slot_index;
	logic [10:0] current_size;
	logic [31:0] found_txns;
	logic [31:0] found_items;
	logic [31:0] found_cents;
	modport source(output valid, status, slot_index, current_size, found_txns,
		found_items, found_cents, input ready);
	modport sink(input valid, status, slot_index, current_size, found_txns,
		found_items, found_cents, output ready);
endinterface

interface oaht_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

[src/oaht_divider.sv]
// Restoring divider: one quotient bit per cycle, remainder only.
module oaht_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oaht_pkg::div_req_t   req,
	output oaht_pkg::div_rsp_t   rsp
);
	logic [23:0] num_q;
	logic [12:0] rem_q;
	logic [11:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [12:0] shifted;

	assign shifted = {rem_q[11:0], num_q[23]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit and subtract the divisor when it fits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[22:0], 1'b0};
			if (shifted >= {1'b0, den_q}) rem_q <= shifted - {1'b0, den_q};
			else rem_q <= shifted;
		end
	end

	assign rsp = {done_q, rem_q[11:0]};
endmodule

[src/oaht_slot_store.sv]
// Two banks of slot records with valid bits kept per bank.
module oaht_slot_store (
	input  logic                       clk,
	input  logic [oaht_pkg::AddrW-1:0] rd_addr,
	output oaht_pkg::slot_rec_t        rd_rec,
	output logic                       rd_valid,
	input  logic                       wr_en,
	input  logic [oaht_pkg::AddrW-1:0] wr_addr,
	input  oaht_pkg::slot_rec_t        wr_rec,
	input  logic                       vclr_en,
	input  logic [oaht_pkg::AddrW-1:0] vclr_addr
);
	oaht_pkg::slot_rec_t mem [0:2*oaht_pkg::MaxSlots-1];
	logic                vmem [0:2*oaht_pkg::MaxSlots-1];

	// Record memory, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_rec;
		rd_rec <= mem[rd_addr];
	end

	// Valid memory; clearing writes zero, record writes set the bit.
	always_ff @(posedge clk) begin
		if (vclr_en) vmem[vclr_addr] <= 1'b0;
		else if (wr_en) vmem[wr_addr] <= 1'b1;
		rd_valid <= vmem[rd_addr];
	end
endmodule

[src/open_addressing_hash_table_top.sv]
// Open-addressing hash table with automatic growth. Each insert or search
// item yields one result item. Items are processed one at a time; a search
// or an insert without growth starts with the home-slot division and then
// divides once per probe step, since every probe position and every prime
// trial goes through one shared remainder unit.
// An insert that grows the table clears the other bank's valid bits (one per
// cycle over all 2048 slots) and re-probes every valid old slot. After reset
// the block runs a clearing pass over both banks' valid bits (all 4096
// entries) before it accepts the first item; configuration writes are taken
// at any time.
module open_addressing_hash_table_top (
	input logic         clk,
	input logic         arst_n,
	oaht_in_if.sink     in_ch,
	oaht_out_if.source  out_ch,
	oaht_cfg_if.sink    cfg
);
	localparam int AW = oaht_pkg::AddrW;

	oaht_pkg::state_t state_q, state_d;
	logic [1:0]  mode_q;
	logic [10:0] size_q, csize_q, idx_q, cur_q, home_q, res_idx_q;
	logic [11:0] nsize_q;
	logic [10:0] ecount_q;
	logic [2:0]  step_q;
	logic [11:0] j_q, last_q;
	logic        bank_q, searching_q, rehash_q, grow_q;
	logic [7:0]  key_q;
	logic [63:0] tag_q;
	logic [31:0] txn_q, itm_q, cts_q;
	logic [11:0] clr_q;
	logic        init_done_q;
	logic [11:0] d_q;
	logic [10:0] ri_q;
	oaht_pkg::slot_rec_t old_q;
	logic        out_valid_q;
	logic [1:0]  st_q;

	oaht_pkg::div_req_t  dreq;
	oaht_pkg::div_rsp_t  drsp;
	oaht_pkg::slot_rec_t rd_rec, wr_rec;
	logic rd_valid, wr_en, vclr_en;
	logic [AW-1:0] rd_addr, wr_addr, vclr_addr;
	logic in_acc, hit, mode_lin, dblbank;
	logic [22:0] jsq;
	logic [23:0] adv;
	logic [7:0] f_l, l_l;
	logic [16:0] key_prod;
	logic [7:0]  key_rem7;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = init_done_q && state_q == oaht_pkg::S_IDLE && !out_valid_q;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign mode_lin    = mode_q == oaht_pkg::PM_LINEAR;
	assign jsq         = 23'(j_q) * 23'(j_q);
	assign f_l         = oaht_pkg::to_lower(in_ch.first_letter);
	assign l_l         = oaht_pkg::to_lower(in_ch.last_letter);
	// Probing over the new bank during rehash, else the active bank.
	assign dblbank     = rehash_q ? ~bank_q : bank_q;

	// Key mod 7 by a reciprocal multiply (293 / 2048), exact for 8-bit keys.
	assign key_prod = 17'(key_q) * 17'd293;
	assign key_rem7 = key_q - 8'(key_prod[16:11]) * 8'(oaht_pkg::StepPrime);

	oaht_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	oaht_slot_store u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_rec(rd_rec),
		.rd_valid(rd_valid), .wr_en(wr_en), .wr_addr(wr_addr), .wr_rec(wr_rec),
		.vclr_en(vclr_en), .vclr_addr(vclr_addr)
	);

	assign hit = searching_q ? (rd_valid && rd_rec.tag == tag_q) : !rd_valid;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			oaht_pkg::S_IDLE:
				if (in_acc) state_d = (in_ch.opcode == oaht_pkg::OP_INSERT &&
					{ecount_q, 1'b0} + 12'd2 > {1'b0, size_q}) ?
					oaht_pkg::S_GROW_START : oaht_pkg::S_PROBE_START;
			oaht_pkg::S_GROW_START: state_d = oaht_pkg::S_PRIME_TRY;
			oaht_pkg::S_PRIME_TRY:
				if (nsize_q > 12'(oaht_pkg::MaxSlots - 1))
					state_d = oaht_pkg::S_DONE;
				else if (d_q * d_q > 24'(nsize_q)) state_d = oaht_pkg::S_PROBE_START;
				else state_d = oaht_pkg::S_PRIME_DIV;
			oaht_pkg::S_PRIME_DIV:
				if (drsp.done) state_d = (drsp.rem == 12'd0) ?
					oaht_pkg::S_PRIME_NEXT : oaht_pkg::S_PRIME_TRY;
			oaht_pkg::S_PRIME_NEXT: state_d = oaht_pkg::S_PRIME_TRY;
			oaht_pkg::S_PROBE_START: state_d = oaht_pkg::S_HOME_DIV;
			oaht_pkg::S_HOME_DIV: if (drsp.done) state_d = oaht_pkg::S_PROBE_RD;
			oaht_pkg::S_PROBE_RD: state_d = oaht_pkg::S_PROBE_WAIT;
			oaht_pkg::S_PROBE_WAIT: state_d = oaht_pkg::S_PROBE_CHK;
			oaht_pkg::S_PROBE_CHK:
				if (hit || j_q >= last_q)
					state_d = rehash_q ? oaht_pkg::S_RH_WRITE :
						searching_q ? oaht_pkg::S_DONE : oaht_pkg::S_INS_WRITE;
				else state_d = oaht_pkg::S_PROBE_ADV;
			oaht_pkg::S_PROBE_ADV: state_d = oaht_pkg::S_PROBE_MOD;
			oaht_pkg::S_PROBE_MOD: if (drsp.done) state_d = oaht_pkg::S_PROBE_RD;
			oaht_pkg::S_INS_WRITE:
				state_d = grow_q ? oaht_pkg::S_CLR : oaht_pkg::S_DONE;
			oaht_pkg::S_CLR:
				if (clr_q[10:0] == 11'(oaht_pkg::MaxSlots - 1)) state_d = oaht_pkg::S_RH_RD;
			oaht_pkg::S_RH_RD:
				state_d = (ri_q == size_q) ? oaht_pkg::S_DONE : oaht_pkg::S_RH_WAIT;
			oaht_pkg::S_RH_WAIT: state_d = oaht_pkg::S_RH_CHK;
			oaht_pkg::S_RH_CHK:
				state_d = rd_valid ? oaht_pkg::S_PROBE_START : oaht_pkg::S_RH_RD;
			oaht_pkg::S_RH_WRITE: state_d = oaht_pkg::S_RH_RD;
			oaht_pkg::S_DONE: state_d = oaht_pkg::S_IDLE;
			default: state_d = oaht_pkg::S_IDLE;
		endcase
	end

	// Divider requests, memory addressing and write data.
	always_comb begin
		dreq     = '0;
		rd_addr  = {dblbank, cur_q};
		wr_en    = 1'b0;
		wr_addr  = {dblbank, cur_q};
		wr_rec   = rehash_q ? old_q :
			oaht_pkg::slot_rec_t'{tag_q, key_q, txn_q, itm_q, cts_q};
		vclr_en  = 1'b0;
		vclr_addr = init_done_q ? {~bank_q, clr_q[10:0]} : clr_q;
		adv      = '0;
		// (home + j*j) mod size gives the same slot as the nested remainder.
		if (mode_lin) adv = 24'(home_q) + 24'(j_q);
		else if (mode_q == oaht_pkg::PM_QUADRATIC) adv = 24'(home_q) + 24'(jsq);
		else adv = 24'(home_q) + 24'(step_q) * 24'(j_q);
		case (state_q)
			oaht_pkg::S_PRIME_TRY: begin
				dreq.dividend = 24'(nsize_q);
				dreq.divisor  = d_q;
				dreq.start    = !(nsize_q > 12'(oaht_pkg::MaxSlots - 1)) &&
					!(d_q * d_q > 24'(nsize_q));
			end
			oaht_pkg::S_PROBE_START: begin
				dreq.start = 1'b1; dreq.dividend = 24'(key_q); dreq.divisor = 12'(csize_q);
			end
			oaht_pkg::S_PROBE_ADV: begin
				dreq.start = 1'b1; dreq.dividend = adv; dreq.divisor = 12'(csize_q);
			end
			oaht_pkg::S_INS_WRITE, oaht_pkg::S_RH_WRITE: wr_en = 1'b1;
			oaht_pkg::S_CLR: vclr_en = 1'b1;
			oaht_pkg::S_RH_RD, oaht_pkg::S_RH_WAIT: rd_addr = {bank_q, ri_q};
			default: ;
		endcase
		if (!init_done_q) vclr_en = 1'b1;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oaht_pkg::S_IDLE;
			mode_q      <= oaht_pkg::PM_LINEAR;
			size_q      <= 11'(oaht_pkg::InitialSize);
			ecount_q    <= '0;
			bank_q      <= 1'b0;
			clr_q       <= '0;
			init_done_q <= 1'b0;
			out_valid_q <= 1'b0;
			rehash_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) mode_q <= cfg.data;
			if (!init_done_q) begin
				clr_q <= clr_q + 12'd1;
				if (clr_q == 12'(2 * oaht_pkg::MaxSlots - 1)) init_done_q <= 1'b1;
			end
			if (state_q == oaht_pkg::S_INS_WRITE) begin
				if (ecount_q != 11'd2047) ecount_q <= ecount_q + 11'd1;
				clr_q <= '0;
			end
			if (state_q == oaht_pkg::S_CLR) clr_q <= clr_q + 12'd1;
			if (state_q == oaht_pkg::S_CLR && state_d == oaht_pkg::S_RH_RD)
				rehash_q <= 1'b1;
			if (state_q == oaht_pkg::S_RH_RD && ri_q == size_q) begin
				rehash_q <= 1'b0;
				bank_q   <= ~bank_q;
				size_q   <= nsize_q[10:0];
			end
			if (state_q == oaht_pkg::S_DONE) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			oaht_pkg::S_IDLE: if (in_acc) begin
				searching_q <= in_ch.opcode != oaht_pkg::OP_INSERT;
				tag_q <= in_ch.name_tag;
				key_q <= (l_l > f_l) ? l_l - f_l : f_l - l_l;
				txn_q <= in_ch.txn_count; itm_q <= in_ch.item_count;
				cts_q <= in_ch.paid_cents;
				csize_q <= size_q;
				grow_q <= 1'b0;
			end
			oaht_pkg::S_GROW_START: begin
				nsize_q <= {size_q, 1'b0}; d_q <= 12'd2; grow_q <= 1'b1;
			end
			oaht_pkg::S_PRIME_TRY:
				if (nsize_q > 12'(oaht_pkg::MaxSlots - 1))
					st_q <= oaht_pkg::ST_FULL;
			oaht_pkg::S_PRIME_DIV: if (drsp.done) begin
				if (drsp.rem == 12'd0) nsize_q <= nsize_q + 12'd1;
				else d_q <= d_q + 12'd1;
			end
			oaht_pkg::S_PRIME_NEXT: d_q <= 12'd2;
			oaht_pkg::S_PROBE_START: begin
				j_q <= '0; d_q <= '0;
				last_q <= mode_lin ? 12'(csize_q) : 12'(csize_q) - 12'd1;
				step_q <= 3'(oaht_pkg::StepPrime) - key_rem7[2:0];
			end
			oaht_pkg::S_HOME_DIV: if (drsp.done) begin
				home_q <= drsp.rem[10:0]; cur_q <= drsp.rem[10:0];
			end
			oaht_pkg::S_PROBE_CHK: if (!(hit || j_q >= last_q)) j_q <= j_q + 12'd1;
			oaht_pkg::S_PROBE_MOD: if (drsp.done) cur_q <= drsp.rem[10:0];
			oaht_pkg::S_INS_WRITE: begin
				res_idx_q <= cur_q; st_q <= oaht_pkg::ST_INSERTED;
				ri_q <= '0; csize_q <= nsize_q[10:0];
			end
			oaht_pkg::S_RH_CHK: begin
				old_q <= rd_rec; key_q <= rd_rec.key;
				if (!rd_valid) ri_q <= ri_q + 11'd1;
			end
			oaht_pkg::S_RH_WRITE: ri_q <= ri_q + 11'd1;
			default: ;
		endcase
		if (state_q == oaht_pkg::S_PROBE_CHK && searching_q) begin
			res_idx_q <= cur_q;
			st_q <= hit ? oaht_pkg::ST_FOUND : oaht_pkg::ST_NOT_FOUND;
			old_q <= rd_rec;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = st_q;
	assign out_ch.slot_index   = (st_q == oaht_pkg::ST_INSERTED ||
		st_q == oaht_pkg::ST_FOUND) ? res_idx_q : 11'd0;
	assign out_ch.current_size = size_q;
	assign out_ch.found_txns   = (st_q == oaht_pkg::ST_FOUND) ? old_q.txns : 32'd0;
	assign out_ch.found_items  = (st_q == oaht_pkg::ST_FOUND) ? old_q.items : 32'd0;
	assign out_ch.found_cents  = (st_q == oaht_pkg::ST_FOUND) ? old_q.cents : 32'd0;
endmodule
